>>> rtl/core/csrspmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csrspmv_pkg;

  // block dimensions
  localparam int unsigned VECTOR_LENGTH = 1024;
  localparam int unsigned MAX_ROWS      = 65536;
  localparam int unsigned VEC_AW        = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

  // item and result field widths
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned PROD_W  = 2 * VALUE_W;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // input opcodes
  localparam logic [1:0] OP_LOAD      = 2'd0;
  localparam logic [1:0] OP_NONZERO   = 2'd1;
  localparam logic [1:0] OP_EMPTY_ROW = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  // saturation limits
  localparam logic [ACC_W-1:0]   ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]   ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] SUM_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] SUM_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]   CNT_MAX = {CNT_W{1'b1}};

  // work kinds handed from front to back
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_MAC,
    KIND_EMPTY
  } kind_t;

  // one classified item in the queue
  typedef struct packed {
    kind_t                      kind;
    logic                       emit;
    logic                       in_range;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/csrspmv_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module csrspmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/csrspmv_front.sv
`timescale 1ns / 1ps
`default_nettype none

module csrspmv_front
  import csrspmv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic [INDEX_W-1:0] index,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               row_end,
  input  wire logic               q_full,
  output logic                    push,
  output entry_t                  push_entry
);

  logic   front_valid;
  entry_t front_entry;
  entry_t entry_next;
  logic   keep;
  logic   accept;

  assign in_stall   = front_valid && q_full;
  assign accept     = in_valid && !in_stall;
  assign push       = front_valid && !q_full;
  assign push_entry = front_entry;

  // classify the incoming item
  always_comb begin
    keep                = 1'b1;
    entry_next.kind     = KIND_LOAD;
    entry_next.emit     = 1'b0;
    entry_next.in_range = (32'(index) < VECTOR_LENGTH);
    entry_next.index    = index;
    entry_next.value    = $signed(value);
    unique case (opcode)
      OP_LOAD: begin
        entry_next.kind = KIND_LOAD;
      end
      OP_NONZERO: begin
        entry_next.kind = KIND_MAC;
        entry_next.emit = row_end;
      end
      OP_EMPTY_ROW: begin
        entry_next.kind = KIND_EMPTY;
        entry_next.emit = 1'b1;
      end
      OP_UNUSED: begin
        keep = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // holding register in front of the queue; unused opcodes are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= keep;
    end else if (push) begin
      front_valid <= 1'b0;
    end
    if (accept) begin
      front_entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/csrspmv_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module csrspmv_queue
  import csrspmv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  entry_t    push_entry,
  output logic      full,
  output logic      not_empty,
  input  wire logic pop,
  output entry_t    head
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (32'(count) == QUEUE_DEPTH);
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (32'(wptr) == QUEUE_DEPTH - 1) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (32'(rptr) == QUEUE_DEPTH - 1) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QUEUE_DEPTH)
    else $error("queue fill count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

>>> rtl/core/csrspmv_back.sv
`timescale 1ns / 1ps
`default_nettype none

module csrspmv_back
  import csrspmv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_not_empty,
  input  entry_t                 head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ROW_W-1:0]       row_number,
  output logic [VALUE_W-1:0]     row_sum,
  output logic [CNT_W-1:0]       nonzero_rows
);

  logic                      adv;
  logic                      ram_we;
  logic [VALUE_W-1:0]        ram_rdata;

  logic                      s1_valid;
  logic                      s1_mac;
  logic                      s1_emit;
  logic                      s1_in_range;
  logic signed [VALUE_W-1:0] s1_value;

  logic                      s2_valid;
  logic                      s2_emit;
  logic signed [PROD_W-1:0]  s2_prod;
  logic signed [PROD_W-1:0]  prod_next;

  logic [ACC_W-1:0]          acc;
  logic [ACC_W-1:0]          acc_next;
  logic [ACC_W:0]            sum_wide;
  logic [ACC_W-1:0]          addend;
  logic [ROW_W-1:0]          row_count;
  logic [ROW_W:0]            row_inc;
  logic [ROW_W-1:0]          row_count_next;
  logic [CNT_W-1:0]          nz_count;
  logic [CNT_W-1:0]          nz_count_next;
  logic [VALUE_W-1:0]        sum_sat;
  logic                      fits32;

  // whole back pipeline moves when the output register can take a result
  assign adv    = !out_valid || !out_stall;
  assign pop    = adv && q_not_empty;
  assign ram_we = pop && (head.kind == KIND_LOAD) && head.in_range;

  csrspmv_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (VECTOR_LENGTH)
  ) u_vector_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (VEC_AW'(head.index)),
    .wdata (head.value),
    .re    (adv),
    .raddr (VEC_AW'(head.index)),
    .rdata (ram_rdata)
  );

  // vector entry times matrix value, zero for empty rows and out-of-range columns
  always_comb begin
    if (s1_mac && s1_in_range) begin
      prod_next = s1_value * $signed(ram_rdata);
    end else begin
      prod_next = '0;
    end
  end

  // product to Q32.16 by dropping 16 fraction bits, then saturating add
  assign addend   = s2_prod[PROD_W-1:16];
  assign sum_wide = {acc[ACC_W-1], acc} + {addend[ACC_W-1], addend};
  always_comb begin
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      acc_next = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = sum_wide[ACC_W-1:0];
    end
  end

  // row result: 32-bit saturation and counters
  assign fits32 = (acc_next[ACC_W-1:VALUE_W-1] == '0) ||
                  (acc_next[ACC_W-1:VALUE_W-1] == '1);
  always_comb begin
    if (fits32) begin
      sum_sat = acc_next[VALUE_W-1:0];
    end else begin
      sum_sat = acc_next[ACC_W-1] ? SUM_MIN : SUM_MAX;
    end
    row_inc = {1'b0, row_count} + 1'b1;
    if (32'(row_inc) >= MAX_ROWS) begin
      row_count_next = '0;
    end else begin
      row_count_next = row_inc[ROW_W-1:0];
    end
    if ((acc_next != '0) && (nz_count != CNT_MAX)) begin
      nz_count_next = nz_count + 1'b1;
    end else begin
      nz_count_next = nz_count;
    end
  end

  // pipeline stages, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
      row_count <= '0;
      nz_count  <= '0;
    end else if (adv) begin
      s1_valid  <= pop && (head.kind != KIND_LOAD);
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_emit;
      if (s2_valid) begin
        if (s2_emit) begin
          acc       <= '0;
          row_count <= row_count_next;
          nz_count  <= nz_count_next;
        end else begin
          acc <= acc_next;
        end
      end
    end
    if (adv) begin
      s1_mac      <= (head.kind == KIND_MAC);
      s1_emit     <= head.emit;
      s1_in_range <= head.in_range;
      s1_value    <= head.value;
      s2_emit     <= s1_emit;
      s2_prod     <= prod_next;
      if (s2_valid && s2_emit) begin
        row_number   <= row_count;
        row_sum      <= sum_sat;
        nonzero_rows <= nz_count_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_load_in_mac: assert property (@(posedge clk) disable iff (rst)
    (adv && pop && (head.kind == KIND_LOAD)) |=> !s1_valid)
    else $error("vector load entered the multiply pipeline");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && s2_emit) |=> out_valid)
    else $error("row end did not produce a result");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && s2_emit) |=> (acc == '0))
    else $error("accumulator not cleared after row result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(acc) && $stable(s2_prod)))
    else $error("back pipeline moved while output held");
`endif

endmodule

`default_nettype wire

>>> rtl/core/csr_spmv_row_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none

// Sparse matrix times dense vector in CSR order, one row sum per row.
// Input channel (in_valid / in_stall): opcode 0 writes value into vector entry
// index, opcode 1 is a matrix nonzero at column index (row_end marks the last
// of its row), opcode 2 is an empty row; opcode 3 is dropped.
// Output channel (out_valid / out_stall): row_number, saturated Q16.16 row_sum
// and the running count of rows with a nonzero sum.
// A transfer on either side happens when valid is high and stall is low.
// Throughput is one item per cycle unless a stalled result holds the back
// pipeline: the accumulator loop is a single saturating add and the vector
// store serves one write or read per cycle. From the input transfer an item
// passes the front register, the queue, the vector store read, the
// multiplier register and the output register, in that order.
// When the receiver stalls a waiting result the back pipeline holds; the queue
// and front register then fill and in_stall rises after at most five more items.
// Synchronous reset clears the counters, accumulator and all valid flags;
// the vector store is not cleared and must be loaded before use.
module csr_spmv_row_accumulator
  import csrspmv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic [INDEX_W-1:0] index,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               row_end,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ROW_W-1:0]        row_number,
  output logic [VALUE_W-1:0]      row_sum,
  output logic [CNT_W-1:0]        nonzero_rows
);

  logic   q_full;
  logic   q_not_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  // classify and hold incoming items
  csrspmv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .index      (index),
    .value      (value),
    .row_end    (row_end),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  csrspmv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .pop        (pop),
    .head       (head)
  );

  // vector store, multiply-accumulate and result register
  csrspmv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_number   (row_number),
    .row_sum      (row_sum),
    .nonzero_rows (nonzero_rows)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import csrspmv_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint SUM_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [VALUE_W-1:0] sum;
    logic [CNT_W-1:0]   nz;
  } row_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = OP_LOAD;
  logic [INDEX_W-1:0] index = '0;
  logic [VALUE_W-1:0] value = '0;
  logic row_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROW_W-1:0] row_number;
  logic [VALUE_W-1:0] row_sum;
  logic [CNT_W-1:0] nonzero_rows;

  // test control flags
  logic sender_calm = 1'b0;
  logic receiver_calm = 1'b0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  // predictor state
  logic [VALUE_W-1:0] vec_mem [VECTOR_LENGTH];
  bit vec_loaded [VECTOR_LENGTH];
  int loaded_cols [$];
  longint acc_model = 0;
  logic [ROW_W-1:0] row_cnt_model = '0;
  logic [CNT_W-1:0] nz_cnt_model = '0;
  row_result_t row_results_due [$];
  row_result_t due_head;

  // run statistics
  int items_sent = 0;
  int rows_checked = 0;
  int errors = 0;
  int stalled_offers = 0;
  int sat_rows = 0;

  csr_spmv_row_accumulator uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .index(index),
    .value(value),
    .row_end(row_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .row_number(row_number),
    .row_sum(row_sum),
    .nonzero_rows(nonzero_rows)
  );

  always #5 clk = ~clk;

  // update the row accumulator model for one accepted item
  function void apply_item(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] val, input logic last);
    longint mult_a, mult_b, acc_next;
    row_result_t res;
    if (op == OP_LOAD) begin
      if (!vec_loaded[idx]) begin
        vec_loaded[idx] = 1'b1;
        loaded_cols.push_back(int'(idx));
      end
      vec_mem[idx] = val;
    end else if (op == OP_NONZERO) begin
      mult_a = longint'($signed(val));
      mult_b = longint'($signed(vec_mem[idx]));
      acc_next = acc_model + ((mult_a * mult_b) >>> 16);
      if (acc_next > ACC_HI) acc_next = ACC_HI;
      if (acc_next < ACC_LO) acc_next = ACC_LO;
      acc_model = acc_next;
    end
    // row sum goes out on row end or an empty row
    if ((op == OP_NONZERO && last) || op == OP_EMPTY_ROW) begin
      if (acc_model != 0 && nz_cnt_model != CNT_MAX) nz_cnt_model++;
      res.row = row_cnt_model;
      res.nz = nz_cnt_model;
      if (acc_model > SUM_HI) begin
        res.sum = SUM_MAX;
        sat_rows++;
      end else if (acc_model < SUM_LO) begin
        res.sum = SUM_MIN;
        sat_rows++;
      end else begin
        res.sum = acc_model[VALUE_W-1:0];
      end
      row_results_due.push_back(res);
      row_cnt_model++;
      acc_model = 0;
    end
  endfunction

  // Q16.16 value: mostly full range, some small, some corner values
  function logic [VALUE_W-1:0] random_q16();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 8) return VALUE_W'($signed($urandom_range(0, 2097152)) - 1048576);
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      4: return 32'hFFFF_FFFF;
      5: return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function logic [INDEX_W-1:0] loaded_column();
    return INDEX_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
  endfunction

  function logic [INDEX_W-1:0] any_index();
    return INDEX_W'($urandom_range(0, 1023));
  endfunction

  function logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // offer one item and wait for its transfer
  task automatic send_item(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] val, input logic last);
    while (!sender_calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    index <= idx;
    value <= val;
    row_end <= last;
    @(posedge clk);
    while (in_stall) begin
      stalled_offers++;
      @(posedge clk);
    end
    apply_item(op, idx, val, last);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // one random action: mostly whole rows, some loads, empty rows and noise
  task automatic send_random_step();
    int pick, n;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) send_item(OP_LOAD, any_index(), random_q16(), any_bit());
    end else if (pick < 20) begin
      send_item(OP_EMPTY_ROW, any_index(), $urandom, any_bit());
    end else if (pick < 25) begin
      case ($urandom_range(0, 2))
        0: send_item(OP_UNUSED, any_index(), $urandom, any_bit());
        1: send_item(OP_NONZERO, loaded_column(), random_q16(), 1'b0);
        default: begin
          send_item(OP_NONZERO, loaded_column(), random_q16(), 1'b0);
          send_item(OP_EMPTY_ROW, any_index(), $urandom, any_bit());
        end
      endcase
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_item(OP_NONZERO, loaded_column(), random_q16(), i == n - 1);
    end
  endtask

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result checker and receiver stall generator
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (row_results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected row result: row %0d sum %h count %0d",
                   $time, row_number, row_sum, nonzero_rows);
        end else begin
          due_head = row_results_due.pop_front();
          rows_checked++;
          if (row_number !== due_head.row) begin
            errors++;
            $display("%0t: row_number mismatch: expected %0d, actual %0d",
                     $time, due_head.row, row_number);
          end
          if (row_sum !== due_head.sum) begin
            errors++;
            $display("%0t: row_sum mismatch (row %0d): expected %h, actual %h",
                     $time, due_head.row, due_head.sum, row_sum);
          end
          if (nonzero_rows !== due_head.nz) begin
            errors++;
            $display("%0t: nonzero_rows mismatch (row %0d): expected %0d, actual %0d",
                     $time, due_head.row, due_head.nz, nonzero_rows);
          end
        end
      end
      // long hold-off while counting, otherwise random stalls
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (receiver_calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 35);
      end
    end
  end

  // vector entries at the address and value extremes
  task automatic test_vector_loads();
    send_item(OP_LOAD, 10'd0, 32'h7FFF_FFFF, 1'b1);
    send_item(OP_LOAD, 10'd1023, 32'h8000_0000, 1'b0);
    send_item(OP_LOAD, 10'd1, 32'h0001_0000, 1'b0);
    send_item(OP_LOAD, 10'd2, 32'hFFFF_0000, 1'b1);
    send_item(OP_LOAD, 10'd4, 32'hFFFF_FFFF, 1'b0);
  endtask

  // rounding, 48-bit accumulator saturation both ways, 32-bit output saturation
  task automatic test_row_arithmetic();
    send_item(OP_NONZERO, 10'd4, 32'h0000_0001, 1'b1);
    repeat (3) send_item(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
    send_item(OP_NONZERO, 10'd0, 32'h8000_0000, 1'b0);
    send_item(OP_NONZERO, 10'd0, 32'h8000_0000, 1'b1);
    // negative saturation, then pulled back to exactly zero
    repeat (3) send_item(OP_NONZERO, 10'd0, 32'h8000_0000, 1'b0);
    send_item(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
    send_item(OP_NONZERO, 10'd1023, 32'h8000_0000, 1'b1);
    send_item(OP_NONZERO, 10'd0, 32'h7FFF_FFFF, 1'b1);
    send_item(OP_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b1);
  endtask

  // empty rows, pending sums, unused opcode and loads inside a row
  task automatic test_special_items();
    send_item(OP_EMPTY_ROW, 10'd1023, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_NONZERO, 10'd1, 32'h0001_8000, 1'b0);
    send_item(OP_EMPTY_ROW, 10'd0, 32'h0000_0000, 1'b0);
    send_item(OP_NONZERO, 10'd2, 32'h0002_0000, 1'b0);
    send_item(OP_UNUSED, 10'd5, 32'h1234_5678, 1'b1);
    send_item(OP_NONZERO, 10'd1, 32'h0001_0000, 1'b1);
    send_item(OP_NONZERO, 10'd1, 32'h7FFF_0000, 1'b0);
    send_item(OP_LOAD, 10'd5, 32'h0001_0000, 1'b1);
    send_item(OP_NONZERO, 10'd5, 32'h8001_0000, 1'b1);
  endtask

  task automatic test_random_rows();
    int start;
    start = items_sent;
    while (items_sent < start + 1000) send_random_step();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_back_pressure();
    int start;
    start = items_sent;
    sender_calm = 1'b1;
    hold_req <= 1'b1;
    while (items_sent < start + 60) send_random_step();
    sender_calm = 1'b0;
  endtask

  // back-to-back transfers on both sides
  task automatic test_full_rate();
    int start;
    start = items_sent;
    sender_calm = 1'b1;
    receiver_calm <= 1'b1;
    while (items_sent < start + 200) send_random_step();
    sender_calm = 1'b0;
    receiver_calm <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_vector_loads();
    test_row_arithmetic();
    test_special_items();
    test_random_rows();
    test_back_pressure();
    test_full_rate();
    in_valid <= 1'b0;
    while (row_results_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Covered %0d items, %0d row results checked (%0d saturated to 32 bits).",
             items_sent, rows_checked, sat_rows);
    $display("Vector entries written: %0d; input offers held off by in_stall: %0d cycles.",
             loaded_cols.size(), stalled_offers);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Timeout with %0d row results still due", row_results_due.size());
    $display("Verification failed");
    $finish;
  end

endmodule
